[rtl/mtep_pkg.sv]
`default_nettype none
package mtep_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CH_W        = 4;
    localparam int unsigned MASK_W      = 16;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned CFG_IDX_W   = 8;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TRK_LEN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICK = CFG_IDX_W'(1);

    localparam logic [PHASE_W-1:0] PH_DELTA     = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_STATUS    = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_DATA1     = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_DATA2     = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] PH_META_TYPE = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PH_META_LEN  = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PH_META_SKIP = PHASE_W'(6);
    localparam logic [PHASE_W-1:0] PH_SKIP_ONE  = PHASE_W'(7);

    localparam logic [BYTE_W-1:0] STATUS_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] HI_MASK     = 8'hF0;
    localparam logic [BYTE_W-1:0] NOTE_ON_HI  = 8'h90;
    localparam logic [BYTE_W-1:0] NOTE_OFF_HI = 8'h80;
    localparam logic [BYTE_W-1:0] META_STATUS = 8'hFF;
    localparam logic [BYTE_W-1:0] DATA_MASK   = 8'h7F;
    localparam logic [BYTE_W-1:0] LO_MASK     = 8'h0F;

    localparam logic KIND_NOTE_ON = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              has_note;
        logic              has_sum;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] note_number;
        logic [BYTE_W-1:0] velocity;
        logic [WORD_W-1:0] tick;
        logic [WORD_W-1:0] note_events;
        logic [MASK_W-1:0] chan_bits;
    } t_entry;

endpackage
`default_nettype wire

[rtl/mtep_front.sv]
`default_nettype none
module mtep_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mtep_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mtep_pkg::WORD_W-1:0]       i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [mtep_pkg::BYTE_W-1:0]       i_byte_value,
    input  wire                               i_q_space,
    output logic                              o_push,
    output mtep_pkg::t_entry                  o_entry
);
    import mtep_pkg::*;

    logic [WORD_W-1:0]  r_trk_len, r_start_tick;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_rs, n_rs;
    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [WORD_W-1:0]  r_tick, n_tick;
    logic [WORD_W-1:0]  r_left, n_left;
    logic [WORD_W-1:0]  r_skip, n_skip;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic [WORD_W-1:0]  r_count, n_count;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic               r_started;

    logic               accept;
    logic               final_byte;
    logic [WORD_W-1:0]  after;
    logic [WORD_W-1:0]  acc_sh;
    logic [WORD_W-1:0]  skip_dec;
    logic               rs_note, rs_on, b_note;
    logic               note_hit;
    logic [CH_W-1:0]    ch;
    logic               cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_q_space;
    assign accept      = i_in_valid && i_q_space;
    assign final_byte  = (r_left <= WORD_W'(1));
    assign after       = final_byte ? '0 : r_left - WORD_W'(1);
    assign acc_sh      = {r_acc[WORD_W-8:0], i_byte_value[6:0]};
    assign skip_dec    = (r_skip != '0) ? r_skip - WORD_W'(1) : r_skip;
    assign rs_note     = ((r_rs & HI_MASK) == NOTE_ON_HI) || ((r_rs & HI_MASK) == NOTE_OFF_HI);
    assign rs_on       = ((r_rs & HI_MASK) == NOTE_ON_HI);
    assign b_note      = ((i_byte_value & HI_MASK) == NOTE_ON_HI)
                      || ((i_byte_value & HI_MASK) == NOTE_OFF_HI);
    assign ch          = r_rs[CH_W-1:0];
    assign cfg_hit     = i_cfg_valid
                      && (i_cfg_index == CFG_TRK_LEN || i_cfg_index == CFG_START_TICK);

    always_comb begin
        n_phase  = r_phase;
        n_rs     = r_rs;
        n_acc    = r_acc;
        n_tick   = r_tick;
        n_skip   = r_skip;
        n_held   = r_held;
        n_count  = r_count;
        n_mask   = r_mask;
        note_hit = 1'b0;
        unique case (r_phase)
            PH_DELTA: begin
                n_acc = acc_sh;
                if (!i_byte_value[7]) begin
                    n_tick  = r_tick + acc_sh;
                    n_acc   = '0;
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS, PH_DATA1, PH_META_TYPE: begin
                if (r_phase == PH_STATUS && i_byte_value[7]) begin
                    n_rs = i_byte_value;
                    if (b_note) begin
                        n_phase = PH_DATA1;
                    end else if (i_byte_value == META_STATUS) begin
                        n_phase = PH_META_TYPE;
                    end else begin
                        n_phase = PH_SKIP_ONE;
                    end
                end else if (rs_note) begin
                    n_held  = i_byte_value;
                    n_phase = PH_DATA2;
                end else if (r_rs == META_STATUS) begin
                    n_acc   = '0;
                    n_phase = PH_META_LEN;
                end else begin
                    n_phase = PH_DELTA;
                end
            end
            PH_DATA2: begin
                if (rs_on) begin
                    if (i_byte_value != '0) begin
                        note_hit = 1'b1;
                        n_count  = r_count + WORD_W'(1);
                        n_mask   = r_mask | (MASK_W'(1) << ch);
                    end
                end else begin
                    n_count = r_count + WORD_W'(1);
                end
                n_phase = PH_DELTA;
            end
            PH_META_LEN: begin
                n_acc = acc_sh;
                if (!i_byte_value[7]) begin
                    if (acc_sh != '0 && acc_sh <= after) begin
                        n_skip  = acc_sh;
                        n_phase = PH_META_SKIP;
                    end else begin
                        n_phase = PH_DELTA;
                    end
                    n_acc = '0;
                end
            end
            PH_META_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            default: begin
                n_phase = PH_DELTA;
            end
        endcase
        n_left = r_left - WORD_W'(1);
    end

    always_comb begin
        o_entry.has_note    = note_hit;
        o_entry.has_sum     = final_byte;
        o_entry.channel     = ch;
        o_entry.note_number = r_held;
        o_entry.velocity    = i_byte_value;
        o_entry.tick        = n_tick;
        o_entry.note_events = n_count;
        o_entry.chan_bits   = n_mask;
    end

    assign o_push = accept && (note_hit || final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk_len    <= WORD_W'(1);
            r_start_tick <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TRK_LEN) begin
                r_trk_len <= i_cfg_data;
            end else if (i_cfg_index == CFG_START_TICK) begin
                r_start_tick <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DELTA;
            r_rs      <= '0;
            r_acc     <= '0;
            r_tick    <= '0;
            r_left    <= WORD_W'(1);
            r_skip    <= '0;
            r_held    <= '0;
            r_count   <= '0;
            r_mask    <= '0;
            r_started <= 1'b0;
        end else if (accept) begin
            if (final_byte) begin
                r_phase   <= PH_DELTA;
                r_rs      <= '0;
                r_acc     <= '0;
                r_tick    <= r_start_tick;
                r_left    <= r_trk_len;
                r_skip    <= '0;
                r_held    <= '0;
                r_count   <= '0;
                r_mask    <= '0;
                r_started <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_rs      <= n_rs;
                r_acc     <= n_acc;
                r_tick    <= n_tick;
                r_left    <= n_left;
                r_skip    <= n_skip;
                r_held    <= n_held;
                r_count   <= n_count;
                r_mask    <= n_mask;
                r_started <= 1'b1;
            end
        end else if (cfg_hit && !r_started) begin
            r_tick <= (i_cfg_index == CFG_START_TICK) ? i_cfg_data : r_start_tick;
            r_left <= (i_cfg_index == CFG_TRK_LEN) ? i_cfg_data : r_trk_len;
        end
    end

endmodule
`default_nettype wire

[rtl/mtep_queue.sv]
`default_nettype none
module mtep_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  mtep_pkg::t_entry i_entry,
    output logic             o_space,
    output logic             o_valid,
    input  wire              i_pop,
    output mtep_pkg::t_entry o_head
);
    import mtep_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_pop;

    assign o_space = (r_cnt < QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/mtep_back.sv]
`default_nettype none
module mtep_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_q_valid,
    input  mtep_pkg::t_entry              i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_kind,
    output logic [mtep_pkg::CH_W-1:0]     o_channel,
    output logic [mtep_pkg::BYTE_W-1:0]   o_note_number,
    output logic [mtep_pkg::BYTE_W-1:0]   o_velocity,
    output logic [mtep_pkg::WORD_W-1:0]   o_tick,
    output logic [mtep_pkg::WORD_W-1:0]   o_note_events,
    output logic [mtep_pkg::MASK_W-1:0]   o_chan_bits,
    output logic                          o_last_of_run
);
    import mtep_pkg::*;

    logic r_valid;
    logic r_note_done;
    logic load;
    logic send_note;

    assign load      = i_q_valid && (!r_valid || i_out_ready);
    assign send_note = i_head.has_note && !r_note_done;
    assign o_pop     = load && !(send_note && i_head.has_sum);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_note_done <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_note_done <= send_note && i_head.has_sum;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (send_note) begin
                o_kind        <= KIND_NOTE_ON;
                o_channel     <= i_head.channel;
                o_note_number <= i_head.note_number;
                o_velocity    <= i_head.velocity;
                o_note_events <= '0;
                o_chan_bits   <= '0;
                o_last_of_run <= !i_head.has_sum;
            end else begin
                o_kind        <= KIND_SUMMARY;
                o_channel     <= '0;
                o_note_number <= '0;
                o_velocity    <= '0;
                o_note_events <= i_head.note_events;
                o_chan_bits   <= i_head.chan_bits;
                o_last_of_run <= 1'b1;
            end
            o_tick <= i_head.tick;
        end
    end

endmodule
`default_nettype wire

[rtl/midi_track_event_parser.sv]
// A result word passes through the queue entry and then the output register before it turns valid.
// Throughput: one byte per cycle while the queue has space; the parser state updates in a single step per byte.
// A byte that ends a note-on and the track yields two output words from one queue entry;
// a four-entry queue between parser and output absorbs that and output stalls.
// Reset (synchronous, active low): track length 1, start tick 0, parser at delta time.
`default_nettype none
module midi_track_event_parser (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mtep_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mtep_pkg::WORD_W-1:0]       i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [mtep_pkg::BYTE_W-1:0]       i_byte_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_kind,
    output logic [mtep_pkg::CH_W-1:0]         o_channel,
    output logic [mtep_pkg::BYTE_W-1:0]       o_note_number,
    output logic [mtep_pkg::BYTE_W-1:0]       o_velocity,
    output logic [mtep_pkg::WORD_W-1:0]       o_tick,
    output logic [mtep_pkg::WORD_W-1:0]       o_note_events,
    output logic [mtep_pkg::MASK_W-1:0]       o_chan_bits,
    output logic                              o_last_of_run
);
    import mtep_pkg::*;

    logic   q_space, q_valid, push, pop;
    t_entry entry, head;

    mtep_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_value (i_byte_value),
        .i_q_space    (q_space),
        .o_push       (push),
        .o_entry      (entry)
    );

    mtep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_head  (head)
    );

    mtep_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_channel     (o_channel),
        .o_note_number (o_note_number),
        .o_velocity    (o_velocity),
        .o_tick        (o_tick),
        .o_note_events (o_note_events),
        .o_chan_bits   (o_chan_bits),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

import mtep_pkg::*;

typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] note_number;
    logic [BYTE_W-1:0] velocity;
    logic [WORD_W-1:0] tick;
    logic [WORD_W-1:0] note_events;
    logic [MASK_W-1:0] chan_bits;
    logic              last_of_run;
} midi_word_t;

class track_parse_board;
    logic [WORD_W-1:0]  trk_len;
    logic [WORD_W-1:0]  start_tick;
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  run_status;
    logic [WORD_W-1:0]  accum;
    logic [WORD_W-1:0]  now_tick;
    logic [WORD_W-1:0]  left;
    logic [WORD_W-1:0]  skip;
    logic [BYTE_W-1:0]  held;
    logic [WORD_W-1:0]  events;
    logic [MASK_W-1:0]  used;
    bit                 started;
    midi_word_t         due_words[$];
    int unsigned        mismatches;

    function new();
        trk_len = 1;
        start_tick = '0;
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        phase = PH_DELTA;
        run_status = '0;
        accum = '0;
        now_tick = start_tick;
        left = trk_len;
        skip = '0;
        held = '0;
        events = '0;
        used = '0;
        started = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        if (idx == CFG_TRK_LEN) begin
            trk_len = data;
        end else if (idx == CFG_START_TICK) begin
            start_tick = data;
        end else begin
            return;
        end
        if (!started) begin
            now_tick = start_tick;
            left = trk_len;
        end
    endfunction

    function void after_status(logic [BYTE_W-1:0] b);
        if ((run_status & HI_MASK) == NOTE_ON_HI || (run_status & HI_MASK) == NOTE_OFF_HI) begin
            held = b;
            phase = PH_DATA2;
        end else if (run_status == META_STATUS) begin
            accum = '0;
            phase = PH_META_LEN;
        end else begin
            phase = PH_DELTA;
        end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] room;
        bit                ends;
        midi_word_t        w;
        room = (left > 1) ? left - 1 : '0;
        ends = (left <= 1);
        started = 1;
        case (phase)
            PH_DELTA: begin
                accum = {accum[WORD_W-8:0], b[6:0]};
                if ((b & STATUS_BIT) == 0) begin
                    now_tick = now_tick + accum;
                    accum = '0;
                    phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if ((b & STATUS_BIT) != 0) begin
                    run_status = b;
                    if ((b & HI_MASK) == NOTE_ON_HI || (b & HI_MASK) == NOTE_OFF_HI) begin
                        phase = PH_DATA1;
                    end else if (b == META_STATUS) begin
                        phase = PH_META_TYPE;
                    end else begin
                        phase = PH_SKIP_ONE;
                    end
                end else begin
                    after_status(b);
                end
            end
            PH_DATA1, PH_META_TYPE: begin
                after_status(b);
            end
            PH_DATA2: begin
                if ((run_status & HI_MASK) == NOTE_ON_HI) begin
                    if (b != 0) begin
                        w = '0;
                        w.kind = KIND_NOTE_ON;
                        w.channel = CH_W'(run_status & LO_MASK);
                        w.note_number = held;
                        w.velocity = b;
                        w.tick = now_tick;
                        w.last_of_run = !ends;
                        due_words.insert(due_words.size(), w);
                        events = events + 1;
                        used = used | (MASK_W'(1) << w.channel);
                    end
                end else begin
                    events = events + 1;
                end
                phase = PH_DELTA;
            end
            PH_META_LEN: begin
                accum = {accum[WORD_W-8:0], b[6:0]};
                if ((b & STATUS_BIT) == 0) begin
                    if (accum != 0 && accum <= room) begin
                        skip = accum;
                        phase = PH_META_SKIP;
                    end else begin
                        phase = PH_DELTA;
                    end
                    accum = '0;
                end
            end
            PH_META_SKIP: begin
                if (skip > 0) skip = skip - 1;
                if (skip == 0) phase = PH_DELTA;
            end
            default: begin
                phase = PH_DELTA;
            end
        endcase
        if (ends) begin
            w = '0;
            w.kind = KIND_SUMMARY;
            w.tick = now_tick;
            w.note_events = events;
            w.chan_bits = used;
            w.last_of_run = 1'b1;
            due_words.insert(due_words.size(), w);
            restart();
        end else begin
            left = left - 1;
        end
    endfunction

    function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_word(midi_word_t got);
        midi_word_t want;
        if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: word with none due, expected nothing, actual kind %0b tick %0h",
                         $time, got.kind, got.tick);
            return;
        end
        want = due_words.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("channel", want.channel, got.channel);
        check_field("note_number", want.note_number, got.note_number);
        check_field("velocity", want.velocity, got.velocity);
        check_field("tick", want.tick, got.tick);
        check_field("note_events", want.note_events, got.note_events);
        check_field("chan_bits", want.chan_bits, got.chan_bits);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned pending();
        return due_words.size();
    endfunction
endclass

module testbench;
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_byte_value;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_kind;
    logic [CH_W-1:0]      o_channel;
    logic [BYTE_W-1:0]    o_note_number;
    logic [BYTE_W-1:0]    o_velocity;
    logic [WORD_W-1:0]    o_tick;
    logic [WORD_W-1:0]    o_note_events;
    logic [MASK_W-1:0]    o_chan_bits;
    logic                 o_last_of_run;

    track_parse_board     board;
    logic [BYTE_W-1:0]    track_bytes[$];
    logic [BYTE_W-1:0]    gen_status;
    midi_word_t           seen_word;
    bit                   quiet;
    bit                   hold_req;
    int unsigned          hold_left;
    int unsigned          stall_left;

    midi_track_event_parser dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic int unsigned stall_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned send_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 299;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15) stall_left = stall_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready) board.take_byte(i_byte_value);
            if (o_out_valid && i_out_ready) begin
                seen_word = '{o_kind, o_channel, o_note_number, o_velocity, o_tick,
                              o_note_events, o_chan_bits, o_last_of_run};
                board.check_word(seen_word);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] data_byte();
        if ($urandom_range(0, 19) == 0) return BYTE_W'($urandom_range(128, 255));
        return BYTE_W'($urandom_range(0, 127));
    endfunction

    function automatic void add_byte(logic [BYTE_W-1:0] b);
        track_bytes.insert(track_bytes.size(), b);
    endfunction

    function automatic void add_vlq(logic [WORD_W-1:0] v);
        logic [6:0] grp[$];
        do begin
            grp.push_front(v[6:0]);
            v = v >> 7;
        end while (v != 0);
        if ($urandom_range(0, 19) == 0) grp.push_front(7'h00);
        for (int i = 0; i < grp.size(); i++)
            add_byte({i != grp.size() - 1, grp[i]});
    endfunction

    function automatic void add_event();
        int unsigned       pick;
        int unsigned       len;
        logic [BYTE_W-1:0] status;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 99)) inside
            [0:39]:  add_vlq('0);
            [40:84]: add_vlq($urandom_range(1, 127));
            [85:96]: add_vlq($urandom_range(128, 2_000_000));
            default: begin
                repeat (5) add_byte(STATUS_BIT | BYTE_W'($urandom));
                add_byte(DATA_MASK & BYTE_W'($urandom));
            end
        endcase
        if (pick < 60) begin
            status = ((pick < 45) ? NOTE_ON_HI : NOTE_OFF_HI) | (LO_MASK & BYTE_W'($urandom));
            if (gen_status != status || $urandom_range(0, 2) == 0) add_byte(status);
            gen_status = status;
            add_byte(data_byte());
            if (pick < 45 && $urandom_range(0, 9) == 0) add_byte('0);
            else add_byte(data_byte());
        end else if (pick < 72) begin
            if (gen_status != META_STATUS || $urandom_range(0, 1) == 0)
                add_byte(META_STATUS);
            gen_status = META_STATUS;
            add_byte(data_byte());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 5);
            add_vlq(len);
            repeat ((len > 8) ? 8 : len) add_byte(BYTE_W'($urandom));
        end else if (pick < 84) begin
            status = BYTE_W'($urandom_range(8'hA0, 8'hFE));
            add_byte(status);
            gen_status = status;
            add_byte(data_byte());
            if ($urandom_range(0, 1) == 0) add_byte(data_byte());
        end else begin
            repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid and hold until every expected word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_all(input bit pause_midway);
        int unsigned n;
        n = track_bytes.size();
        for (int k = 0; k < n; k++) begin
            send_byte(track_bytes[k], send_gap());
            if (pause_midway && k == n / 2) drain();
        end
    endtask

    initial begin
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] first_tick;
        int unsigned       count;
        board = new();
        quiet = 0;
        hold_req = 0;
        hold_left = 0;
        stall_left = 0;
        gen_status = '0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_byte_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_TRK_LEN, 32'd36);
        write_reg(CFG_START_TICK, 32'hFFFF_FFF0);
        track_bytes = '{8'h00, 8'h40,
                        8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                        8'h90, 8'h00, 8'h01,
                        8'hFF, 8'h01, 8'h7F,
                        8'h00, 8'h9F, 8'hFF, 8'hFF,
                        8'h00, 8'h80, 8'h3C, 8'h00,
                        8'h00, 8'hF0, 8'h05,
                        8'h00, 8'hFF, 8'h51, 8'h01, 8'hAA,
                        8'h00, 8'h3C, 8'h00,
                        8'h00, 8'h95, 8'h40, 8'h7F};
        send_all(0);
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin
                    len = '0;
                    first_tick = '0;
                    count = 30;
                end
                1: begin
                    len = 32'd1;
                    first_tick = '1;
                    count = 20;
                end
                2: begin
                    len = 32'd3;
                    first_tick = $urandom;
                    count = 60;
                end
                9: begin
                    len = '1;
                    first_tick = '1;
                    count = 100;
                end
                default: begin
                    len = $urandom_range(4, 80);
                    first_tick = $urandom;
                    count = 90;
                end
            endcase
            quiet = (p == 4);
            write_reg(CFG_TRK_LEN, len);
            write_reg(CFG_START_TICK, first_tick);
            track_bytes.delete();
            while (track_bytes.size() < count) add_event();
            if (p == 3) hold_req = 1;
            send_all(p == 5);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** midi_track_event_parser: PASSED **");
        end else begin
            $display("** midi_track_event_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("** midi_track_event_parser: FAILED **");
        $finish;
    end
endmodule

[sim.f]
rtl/mtep_pkg.sv
rtl/mtep_front.sv
rtl/mtep_queue.sv
rtl/mtep_back.sv
rtl/midi_track_event_parser.sv
sim/testbench.sv
